FILE: rtl/rtcp_compound_feedback_parser_defines.svh
// Assertion macros for the RTCP compound feedback parser.
// Included by the top level; needs no other file.
`ifndef RTCP_COMPOUND_FEEDBACK_PARSER_DEFINES_SVH
`define RTCP_COMPOUND_FEEDBACK_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property checked on every rising clock edge outside reset.
`define RCFP_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define RCFP_ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define RCFP_ASSERT(label, clk, rstn, prop, msg)
`define RCFP_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

FILE: rtl/rcfp_pkg.sv
// Shared types, constants and helpers of the RTCP compound feedback parser.
// No dependencies.
package rcfp_pkg;

  localparam int unsigned NackCapacity = 32;
  localparam int unsigned FillW        = $clog2(NackCapacity + 1);
  localparam int unsigned AddrW        = (NackCapacity > 1) ? $clog2(NackCapacity) : 1;
  localparam int unsigned IdxW         = 18;
  localparam int unsigned OutDataW     = 104;

  localparam logic [7:0] PtRr   = 8'd201;
  localparam logic [7:0] PtPsfb = 8'd206;
  localparam logic [7:0] PtRtfb = 8'd205;
  localparam logic [4:0] FmtOne = 5'd1;
  localparam logic [1:0] RtcpVersion = 2'd2;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_SEQ   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } item_kind_e;

  typedef enum logic [1:0] {
    EV_UNKNOWN = 2'd0,
    EV_RR      = 2'd1,
    EV_PLI     = 2'd2,
    EV_NACK    = 2'd3
  } event_kind_e;

  typedef enum logic [2:0] {
    S_IN,
    S_EXPAND,
    S_EVENT,
    S_SEQ,
    S_DONE,
    S_ERR
  } state_e;

  // Commands from the sequencer to the NACK unit.
  typedef struct packed {
    logic              start;
    logic              clear;
    logic [31:0]       fci;
    logic [FillW-1:0]  rd_idx;
  } nack_ctrl_t;

  // Status of the NACK unit.
  typedef struct packed {
    logic              busy;
    logic [FillW-1:0]  fill;
    logic              dropped;
    logic [15:0]       rdata;
  } nack_stat_t;

  // Classify a sub-packet from its type (bits 12..5) and format (bits 4..0).
  function automatic event_kind_e event_kind_of(logic [12:0] tf);
    event_kind_e ek;
    ek = EV_UNKNOWN;
    if (tf[12:5] == PtRr) ek = EV_RR;
    else if (tf[12:5] == PtPsfb && tf[4:0] == FmtOne) ek = EV_PLI;
    else if (tf[12:5] == PtRtfb && tf[4:0] == FmtOne) ek = EV_NACK;
    return ek;
  endfunction

endpackage

FILE: rtl/rcfp_nack_unit.sv
// NACK expansion unit: one shared adder walks a PID/BLP word bit by bit
// and fills the sequence store; also serves the registered read port. Uses rcfp_pkg.
module rcfp_nack_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcfp_pkg::nack_ctrl_t ctrl_i,
  output rcfp_pkg::nack_stat_t stat_o
);
  import rcfp_pkg::*;

  logic [15:0]      mem [NackCapacity];
  logic [15:0]      pid_q, rdata_q;
  logic [16:0]      mask_q, mask_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             drop_q, drop_d;
  logic [15:0]      seq;
  logic             push, room;

  // Shared adder: PID plus bit offset.
  assign seq  = pid_q + {11'd0, cnt_q};
  assign push = busy_q && mask_q[0];
  assign room = fill_q < FillW'(NackCapacity);

  // Sequencing of the expansion.
  always_comb begin
    mask_d = mask_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    fill_d = fill_q;
    drop_d = drop_q;
    if (ctrl_i.clear) begin
      fill_d = '0;
      drop_d = 1'b0;
      busy_d = 1'b0;
    end else if (ctrl_i.start) begin
      mask_d = {ctrl_i.fci[15:0], 1'b1};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      mask_d = {1'b0, mask_q[16:1]};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'd16) busy_d = 1'b0;
      if (push) begin
        if (room) fill_d = fill_q + FillW'(1);
        else drop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fill_q <= '0;
      drop_q <= 1'b0;
      cnt_q  <= '0;
      mask_q <= '0;
    end else begin
      busy_q <= busy_d;
      fill_q <= fill_d;
      drop_q <= drop_d;
      cnt_q  <= cnt_d;
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) pid_q <= ctrl_i.fci[31:16];
  end

  // Sequence store with one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (push && room && !ctrl_i.clear) mem[fill_q[AddrW-1:0]] <= seq;
    rdata_q <= mem[ctrl_i.rd_idx[AddrW-1:0]];
  end

  assign stat_o.busy    = busy_q;
  assign stat_o.fill    = fill_q;
  assign stat_o.dropped = drop_q;
  assign stat_o.rdata   = rdata_q;

endmodule

FILE: rtl/rtcp_compound_feedback_parser.sv
// Top level of the RTCP compound feedback parser: header parsing, sequencer
// and output register. Depends on rcfp_pkg, rcfp_nack_unit and the defines header.
//
//  Channel | Dir | tdata                                          | tuser     | tlast
//  s_axis  | in  | data_byte[7:0]                                 | -         | last_byte
//  m_axis  | out | packet_type, format_count, event_kind, sender, | item_kind | last_of_run
//          |     | media, nack_total, nack_overflow, lost_seq     |           |
//
// A byte that completes a NACK FCI word holds the input while the shared adder
// expands all 17 positions. A completed sub-packet then emits one result per
// cycle while the output is taken: the event, the stored entries, and done
// after the last sub-packet of the compound packet.
// Reset clears all control state; the sequence store needs no clearing.
// Output stalls hold the sequencer; the input is ready only while parsing.
`include "rtcp_compound_feedback_parser_defines.svh"
module rtcp_compound_feedback_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte[7:0]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] packet_type, [12:8] format_count, [14:13] event_kind,
  // [46:15] sender_sync_id, [78:47] media_sync_id, [84:79] nack_total,
  // [85] nack_overflow, [101:86] lost_sequence, [103:102] zero
  output logic [rcfp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // item_kind[1:0]
  output logic         m_axis_tlast
);
  import rcfp_pkg::*;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d, len_q, len_d, len_cur;
  logic [12:0]       tf_q, tf_d;
  logic [63:0]       ssrc_q, ssrc_d;
  logic [31:0]       fci_q, fci_d;
  logic              swallow_q, swallow_d;
  logic              lastp_q, lastp_d, emitp_q, emitp_d;
  logic [FillW-1:0]  rd_q, rd_d;
  nack_ctrl_t        nctl;
  nack_stat_t        nst;

  logic              out_v_q, out_v_d, out_last_q, out_last_d;
  item_kind_e        out_kind_q, out_kind_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic              take, free, fail, complete, fci_done, clear_sub;
  logic              nack_start;
  logic              last_seq;
  event_kind_e       ek;
  logic [2:0]        lane;
  logic [IdxW:0]     rr_min;

  rcfp_nack_unit u_nack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (nctl),
    .stat_o (nst)
  );

  assign s_axis_tready = (state_q == S_IN);
  assign take          = s_axis_tvalid && s_axis_tready;
  assign free          = !out_v_q || m_axis_tready;
  assign ek            = event_kind_of(tf_q);
  assign lane          = 3'd3 - idx_q[2:0];
  assign rr_min        = (IdxW+1)'(4) + (IdxW+1)'({tf_q[4:0], 4'd0})
                         + (IdxW+1)'({tf_q[4:0], 3'd0});
  assign len_cur       = (idx_q == IdxW'(3)) ? (len_q | IdxW'({s_axis_tdata, 2'b00})) : len_q;
  assign last_seq      = (rd_q + FillW'(1)) == nst.fill;

  // Decode of the accepted byte.
  always_comb begin
    fail     = 1'b0;
    fci_done = 1'b0;
    if (idx_q == '0) begin
      fail = s_axis_tdata[7:6] != RtcpVersion;
    end else if (idx_q == IdxW'(3)) begin
      if (ek == EV_RR && {1'b0, len_cur} < rr_min) fail = 1'b1;
      if (ek == EV_PLI && len_cur != IdxW'(8)) fail = 1'b1;
      if (ek == EV_NACK && len_cur < IdxW'(8)) fail = 1'b1;
    end else if (idx_q >= IdxW'(12) && ek == EV_NACK) begin
      fci_done = idx_q[1:0] == 2'd3;
    end
    complete = !fail && idx_q >= IdxW'(3) && ({1'b0, idx_q} == {1'b0, len_cur} + (IdxW+1)'(3));
    if (!fail && !complete && s_axis_tlast) fail = 1'b1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IN: begin
        if (take && !swallow_q) begin
          if (fail) state_d = S_ERR;
          else if (fci_done) state_d = S_EXPAND;
          else if (complete) state_d = S_EVENT;
        end
      end
      S_EXPAND: if (!nst.busy) state_d = emitp_q ? S_EVENT : S_IN;
      S_EVENT: begin
        if (free) begin
          if (nst.fill != '0) state_d = S_SEQ;
          else state_d = lastp_q ? S_DONE : S_IN;
        end
      end
      S_SEQ: if (free && last_seq) state_d = lastp_q ? S_DONE : S_IN;
      S_DONE: if (free) state_d = S_IN;
      S_ERR: if (free) state_d = S_IN;
      default: state_d = S_IN;
    endcase
  end

  // Parser registers and NACK unit commands.
  always_comb begin
    idx_d     = idx_q;
    len_d     = len_q;
    tf_d      = tf_q;
    ssrc_d    = ssrc_q;
    fci_d     = fci_q;
    swallow_d = swallow_q;
    lastp_d   = lastp_q;
    emitp_d   = emitp_q;
    clear_sub = 1'b0;
    nack_start = 1'b0;
    if (take) begin
      if (swallow_q) begin
        if (s_axis_tlast) swallow_d = 1'b0;
      end else begin
        if (idx_q == '0) tf_d = {8'd0, s_axis_tdata[4:0]};
        else if (idx_q == IdxW'(1)) tf_d = {s_axis_tdata, tf_q[4:0]};
        else if (idx_q == IdxW'(2)) len_d = IdxW'({s_axis_tdata, 10'd0});
        else if (idx_q == IdxW'(3)) len_d = len_cur;
        else begin
          if (ek != EV_UNKNOWN && idx_q < IdxW'(12)) ssrc_d[lane*8 +: 8] = s_axis_tdata;
          if (ek == EV_NACK && idx_q >= IdxW'(12)) fci_d = {fci_q[23:0], s_axis_tdata};
        end
        if (!complete) idx_d = idx_q + IdxW'(1);
        lastp_d = s_axis_tlast;
        emitp_d = complete;
        if (fail) begin
          clear_sub = 1'b1;
          swallow_d = !s_axis_tlast;
        end else if (fci_done) begin
          nack_start = 1'b1;
        end
      end
    end
    if ((state_q == S_EVENT && free && nst.fill == '0)
        || (state_q == S_SEQ && free && last_seq)) clear_sub = 1'b1;
    if (clear_sub) begin
      idx_d  = '0;
      len_d  = '0;
      tf_d   = '0;
      ssrc_d = '0;
      fci_d  = '0;
    end
  end

  assign nctl.start  = nack_start;
  assign nctl.clear  = clear_sub;
  assign nctl.fci    = fci_d;
  assign nctl.rd_idx = rd_d;

  // Read pointer of the sequence store, aligned with its registered data.
  always_comb begin
    rd_d = '0;
    if (state_q == S_SEQ) rd_d = free ? rd_q + FillW'(1) : rd_q;
  end

  // Output register loads.
  always_comb begin
    out_v_d    = out_v_q && !m_axis_tready;
    out_kind_d = out_kind_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    if (free) begin
      unique case (state_q)
        S_EVENT: begin
          out_v_d    = 1'b1;
          out_kind_d = KIND_EVENT;
          out_last_d = nst.fill == '0 && !lastp_q;
          out_data_d = '0;
          out_data_d[7:0]   = tf_q[12:5];
          out_data_d[12:8]  = tf_q[4:0];
          out_data_d[14:13] = ek;
          out_data_d[46:15] = ssrc_q[63:32];
          out_data_d[78:47] = (ek == EV_RR && tf_q[4:0] == '0) ? 32'd0 : ssrc_q[31:0];
          out_data_d[84:79] = 6'(nst.fill);
          out_data_d[85]    = nst.dropped;
        end
        S_SEQ: begin
          out_v_d    = 1'b1;
          out_kind_d = KIND_SEQ;
          out_last_d = last_seq && !lastp_q;
          out_data_d = '0;
          out_data_d[101:86] = nst.rdata;
        end
        S_DONE, S_ERR: begin
          out_v_d    = 1'b1;
          out_kind_d = (state_q == S_DONE) ? KIND_DONE : KIND_ERROR;
          out_last_d = 1'b1;
          out_data_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IN;
      idx_q     <= '0;
      len_q     <= '0;
      tf_q      <= '0;
      ssrc_q    <= '0;
      fci_q     <= '0;
      swallow_q <= 1'b0;
      lastp_q   <= 1'b0;
      emitp_q   <= 1'b0;
      rd_q      <= '0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      tf_q      <= tf_d;
      ssrc_q    <= ssrc_d;
      fci_q     <= fci_d;
      swallow_q <= swallow_d;
      lastp_q   <= lastp_d;
      emitp_q   <= emitp_d;
      rd_q      <= rd_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // Consistency checks.
  `RCFP_ASSERT(a_err_last, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser == KIND_ERROR) |-> m_axis_tlast, "error item without last_of_run")
  `RCFP_ASSERT(a_fill_cap, clk_i, rst_ni, nst.fill <= FillW'(NackCapacity), "nack fill beyond capacity")
  `RCFP_ASSERT(a_swallow_idle, clk_i, rst_ni, swallow_q |-> (idx_q == '0 && (state_q == S_IN || state_q == S_ERR)), "swallowing outside idle parse")
  `RCFP_ASSERT_NEVER(a_ready_busy, clk_i, rst_ni, s_axis_tready && nst.busy, "input ready while expanding")

endmodule
